FILE: design/spi_register_access_master_unit_macros.svh
// Assertion macros for the SPI register access master checker.
// Depends on nothing; included by the checker file.
`ifndef SPI_REGISTER_ACCESS_MASTER_UNIT_MACROS_SVH
`define SPI_REGISTER_ACCESS_MASTER_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define SPRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SPRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sprm_pkg.sv
// Constants and helpers for the SPI register access master.
// No dependencies; imported by the top level.
package sprm_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned BYTE_W  = 2;

  localparam logic [7:0]         CMD_READ   = 8'h60;
  localparam logic [7:0]         CMD_WRITE  = 8'h20;
  localparam logic [PHASE_W-1:0] LAST_PHASE = 5'd18;
  localparam logic [BYTE_W-1:0]  LAST_BYTE  = 2'd2;
  localparam logic [BYTE_W-1:0]  MID_BYTE   = 2'd1;

  function automatic logic [4:0] rev5(input logic [4:0] a);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) begin
      r[4-i] = a[i];
    end
    return r;
  endfunction

endpackage

FILE: design/spi_register_access_master_unit.sv
// SPI mode-3 register access master, one half-bit tick per request.
// Depends on sprm_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_ready  | start_req opcode reg_addr write_data miso
//   out     | out_valid / out_ready| sclk mosi cs_n busy_res done_res read_data
//
// One request per cycle unless the output stalls; its result appears in the output register in the following cycle.
// Each request yields exactly one result. A frame is 3 bytes of 19 ticks each.
// in_ready is low only while a result is held and out_ready is low.
// rst is synchronous and returns the block to idle with no result pending.
module spi_register_access_master_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_req,
  input  logic       opcode,
  input  logic [4:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       miso,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       sclk,
  output logic       mosi,
  output logic       cs_n,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data
);
  import sprm_pkg::*;

  logic [PHASE_W-1:0] phase_count, phase_count_next, cur_phase;
  logic [BYTE_W-1:0]  byte_index, byte_index_next, cur_byte;
  logic [7:0]         tx_shift, tx_shift_next, cur_tx;
  logic [7:0]         rx_shift, rx_shift_next;
  logic [7:0]         held_write_data, cur_held;
  logic               active, active_next;
  logic               start_now, run, accept;
  logic [7:0]         cmd_byte;
  logic               sclk_next, mosi_next, cs_n_next, done_next;
  logic [7:0]         read_data_next;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign start_now = !active && start_req;
  assign run       = active || start_req;
  assign cmd_byte  = (opcode ? CMD_WRITE : CMD_READ) | {3'b000, rev5(reg_addr)};
  assign cur_phase = start_now ? '0 : phase_count;
  assign cur_byte  = start_now ? '0 : byte_index;
  assign cur_tx    = start_now ? cmd_byte : tx_shift;
  assign cur_held  = start_now ? (opcode ? write_data : 8'h00) : held_write_data;

  always_comb begin
    phase_count_next = phase_count;
    byte_index_next  = byte_index;
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    active_next      = active;
    sclk_next        = 1'b1;
    mosi_next        = 1'b0;
    cs_n_next        = 1'b1;
    done_next        = 1'b0;
    read_data_next   = 8'h00;
    if (run) begin
      active_next     = 1'b1;
      byte_index_next = cur_byte;
      tx_shift_next   = cur_tx;
      priority if (cur_phase == '0) begin
        rx_shift_next = 8'h00;
        if (cur_byte == MID_BYTE) begin
          tx_shift_next = 8'h00;
        end else if (cur_byte >= LAST_BYTE) begin
          tx_shift_next = cur_held;
        end
        phase_count_next = PHASE_W'(1);
      end else if (cur_phase == PHASE_W'(1)) begin
        cs_n_next        = 1'b0;
        phase_count_next = PHASE_W'(2);
      end else if (cur_phase < LAST_PHASE) begin
        cs_n_next = 1'b0;
        mosi_next = cur_tx[7];
        if (!cur_phase[0]) begin
          sclk_next = 1'b0;
        end else begin
          rx_shift_next = {rx_shift[6:0], miso};
          tx_shift_next = {cur_tx[6:0], 1'b0};
        end
        phase_count_next = cur_phase + PHASE_W'(1);
      end else begin
        phase_count_next = '0;
        if (cur_byte >= LAST_BYTE) begin
          done_next       = 1'b1;
          read_data_next  = rx_shift;
          active_next     = 1'b0;
          byte_index_next = '0;
        end else begin
          byte_index_next = cur_byte + BYTE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count     <= '0;
      byte_index      <= '0;
      tx_shift        <= '0;
      rx_shift        <= '0;
      held_write_data <= '0;
      active          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase_count     <= phase_count_next;
        byte_index      <= byte_index_next;
        tx_shift        <= tx_shift_next;
        rx_shift        <= rx_shift_next;
        held_write_data <= cur_held;
        active          <= active_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sclk      <= sclk_next;
      mosi      <= mosi_next;
      cs_n      <= cs_n_next;
      busy_res  <= active_next;
      done_res  <= done_next;
      read_data <= read_data_next;
    end
  end

endmodule

FILE: design/sprm_checker.sv
// Port-level checks for the SPI register access master, bound to the top level.
// Depends on spi_register_access_master_unit_macros.svh.
module sprm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       sclk,
  input logic       mosi,
  input logic       cs_n,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_data
);
`include "spi_register_access_master_unit_macros.svh"

  logic       shown_done, shown_idle, shown_data, shown_low, stalled;
  logic [9:0] res_bits;

  assign shown_done = out_valid && done_res;
  assign shown_idle = out_valid && !busy_res;
  assign shown_data = out_valid && !done_res;
  assign shown_low  = out_valid && !sclk;
  assign stalled    = out_valid && !out_ready;
  assign res_bits   = {out_valid, done_res, read_data};

  `SPRM_ASSERT_NOW(a_done_not_busy, clk, rst, shown_done, !busy_res, "done while busy")
  `SPRM_ASSERT_NOW(a_idle_pins, clk, rst, shown_idle, sclk && cs_n && !mosi, "idle pins wrong")
  `SPRM_ASSERT_NOW(a_rdata_zero, clk, rst, shown_data, read_data == 8'h00, "data without done")
  `SPRM_ASSERT_NOW(a_clk_low_selected, clk, rst, shown_low, !cs_n, "clock low while deselected")
  `SPRM_ASSERT_NEXT(a_out_hold, clk, rst, stalled, $stable(res_bits), "result changed")

endmodule

bind spi_register_access_master_unit sprm_checker u_sprm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sclk      (sclk),
  .mosi      (mosi),
  .cs_n      (cs_n),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .read_data (read_data)
);
